/* src/ifs_fern_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fern IFS package
// Field widths, map codes, thresholds, affine coefficients and the shared
// fixed-point helpers for the fern point generator.
// ----------------------------------------------------------------------------
package ifs_fern_pkg;

   localparam int FRAC_W    = 16;
   localparam int POINT_W   = 24;
   localparam int SHADE_W   = 4;
   localparam int STEP_W    = 8;
   localparam int COEF_W    = 18;
   localparam int PROD_W    = COEF_W + POINT_W;
   localparam int ACC_W     = PROD_W + 1;

   localparam logic [SHADE_W-1:0] MAX_SHADE    = 4'd10;
   localparam int                 SHADE_PERIOD = int'(MAX_SHADE) + 5;
   localparam int                 THRESH_W     = SHADE_W + STEP_W - 3;

   localparam logic [FRAC_W-1:0] THR_0 = 16'd54395;
   localparam logic [FRAC_W-1:0] THR_1 = 16'd59638;
   localparam logic [FRAC_W-1:0] THR_2 = 16'd64881;

   localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

   localparam logic signed [ACC_W-1:0]   ROUND_HALF = ACC_W'(32768);
   localparam logic signed [POINT_W-1:0] Q_MIN      = {1'b1, {(POINT_W-1){1'b0}}};
   localparam logic signed [POINT_W-1:0] Q_MAX      = {1'b0, {(POINT_W-1){1'b1}}};

   typedef enum logic [1:0] {
      MAP_STEM   = 2'd0,
      MAP_RIGHT  = 2'd1,
      MAP_LEFT   = 2'd2,
      MAP_RETURN = 2'd3
   } map_type;

   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [POINT_W-1:0] point_type;

   typedef struct packed {
      coef_type ax;
      coef_type bx;
      coef_type ay;
      coef_type by;
      coef_type cy;
   } coef_set_type;

   typedef struct packed {
      point_type          point_x;
      point_type          point_y;
      map_type            map_chosen;
      logic [SHADE_W-1:0] shade_index;
   } result_type;

   function automatic map_type select_map(input logic [FRAC_W-1:0] r);
      map_type m;
      if (r < THR_0) begin
         m = MAP_STEM;
      end else if (r < THR_1) begin
         m = MAP_RIGHT;
      end else if (r < THR_2) begin
         m = MAP_LEFT;
      end else begin
         m = MAP_RETURN;
      end
      return m;
   endfunction

   function automatic coef_set_type map_coefs(input map_type m);
      coef_set_type c;
      unique case (m)
         MAP_STEM: begin
            c = '{ax: 18'sd56361, bx: 18'sd1966, ay: -18'sd1966, by: 18'sd56361,
                  cy: 18'sd98304};
         end
         MAP_RIGHT: begin
            c = '{ax: 18'sd1311, bx: -18'sd16384, ay: 18'sd13763, by: 18'sd15073,
                  cy: 18'sd98304};
         end
         MAP_LEFT: begin
            c = '{ax: -18'sd9830, bx: 18'sd17695, ay: 18'sd16384, by: 18'sd17039,
                  cy: 18'sd29491};
         end
         default: begin
            c = '{ax: 18'sd0, bx: 18'sd0, ay: 18'sd0, by: 18'sd11141, cy: 18'sd0};
         end
      endcase
      return c;
   endfunction

   // round Q.32 sum to nearest Q.16 (ties up), add offset, saturate
   function automatic point_type affine(input coef_type a, input coef_type b,
                                        input coef_type c, input point_type x,
                                        input point_type y);
      logic signed [PROD_W-1:0] pa;
      logic signed [PROD_W-1:0] pb;
      logic signed [ACC_W-1:0]  s;
      logic signed [ACC_W-1:0]  v;
      point_type                res;
      pa = PROD_W'(a) * PROD_W'(x);
      pb = PROD_W'(b) * PROD_W'(y);
      s  = ACC_W'(pa) + ACC_W'(pb) + ROUND_HALF;
      v  = (s >>> 16) + ACC_W'(c);
      if (v > ACC_W'(Q_MAX)) begin
         res = Q_MAX;
      end else if (v < ACC_W'(Q_MIN)) begin
         res = Q_MIN;
      end else begin
         res = v[POINT_W-1:0];
      end
      return res;
   endfunction

endpackage

/* src/ifs_fern_point_generator_top.sv */
`timescale 1ns / 1ps
// A result is registered in the output buffer before it appears on rsp_.
// Throughput: one beat per cycle while req_ready is high; the point feedback loop (two
// constant-set multiplies, an add, round and saturate) is combinational.
// A two-entry output buffer keeps req_ready independent of rsp_ready.
// Reset (synchronous, active high) clears the kept point, shade index,
// step counter and the output buffer.
// ----------------------------------------------------------------------------
// Fern IFS point generator
// Picks one of four affine maps per random beat, applies it to the kept
// point and emits the new point with its map and shade index.
// ----------------------------------------------------------------------------
module ifs_fern_point_generator_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ifs_fern_pkg::FRAC_W-1:0]       req_random_fraction,
   input  logic                                  req_frame_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [ifs_fern_pkg::POINT_W-1:0] rsp_point_x,
   output logic signed [ifs_fern_pkg::POINT_W-1:0] rsp_point_y,
   output logic [1:0]                            rsp_map_chosen,
   output logic [ifs_fern_pkg::SHADE_W-1:0]      rsp_shade_index
);
   import ifs_fern_pkg::*;

   point_type          cur_x_ff, cur_x_in;
   point_type          cur_y_ff, cur_y_in;
   logic [SHADE_W-1:0] shade_ff, shade_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;

   result_type         out_ff, out_in;
   logic               out_valid_ff, out_valid_in;
   result_type         skid_ff, skid_in;
   logic               skid_valid_ff, skid_valid_in;

   logic               req_beat;
   logic               rsp_beat;
   result_type         result;
   map_type            map_sel;
   coef_set_type       coefs;
   logic [SHADE_W-1:0] shade_base;
   logic [STEP_W-1:0]  steps_base;
   logic [STEP_W-1:0]  steps_inc;
   logic [SHADE_W-1:0] shade_emit;
   logic [STEP_W-1:0]  steps_kept;
   logic [THRESH_W-1:0] climb_level;

   assign req_ready = !skid_valid_ff;
   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = out_valid_ff && rsp_ready;

   // map and new point
   always_comb begin
      map_sel = select_map(req_random_fraction);
      coefs   = map_coefs(map_sel);
      result.point_x    = affine(coefs.ax, coefs.bx, '0, cur_x_ff, cur_y_ff);
      result.point_y    = affine(coefs.ay, coefs.by, coefs.cy, cur_x_ff, cur_y_ff);
      result.map_chosen = map_sel;
      result.shade_index = shade_emit;
   end

   // shade and step counter
   always_comb begin
      shade_base  = req_frame_start ? '0 : shade_ff;
      steps_base  = req_frame_start ? '0 : steps_ff;
      steps_inc   = (steps_base != STEP_MAX) ? steps_base + 1'b1 : steps_base;
      shade_emit  = (map_sel == MAP_RETURN) ? '0 : shade_base;
      steps_kept  = (map_sel == MAP_RETURN) ? '0 : steps_inc;
      climb_level = THRESH_W'({1'b0, shade_emit} + 1'b1) * THRESH_W'(SHADE_PERIOD);
      if (shade_emit < MAX_SHADE && THRESH_W'(steps_kept) >= climb_level) begin
         shade_in = shade_emit + 1'b1;
      end else begin
         shade_in = shade_emit;
      end
      steps_in = steps_kept;
      cur_x_in = result.point_x;
      cur_y_in = result.point_y;
   end

   // output buffer: main register plus skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_beat) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = req_beat;
         end
      end else if (req_beat) begin
         if (!out_valid_ff) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         shade_ff      <= '0;
         steps_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_beat) begin
            cur_x_ff <= cur_x_in;
            cur_y_ff <= cur_y_in;
            shade_ff <= shade_in;
            steps_ff <= steps_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_point_x     = out_ff.point_x;
   assign rsp_point_y     = out_ff.point_y;
   assign rsp_map_chosen  = out_ff.map_chosen;
   assign rsp_shade_index = out_ff.shade_index;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fern IFS point generator testbench
// Drives random-fraction beats into the generator and checks every point,
// map code and shade index against a fixed-point model of the four affine
// maps and the shade climb kept here. Both sides idle in random bursts, and
// the receiver holds off for long stretches so the block back-pressures.
// Directed beats cover the map thresholds and frame starts; long runs with
// no return map drive the shade to its top and the step count to saturation.
// ----------------------------------------------------------------------------
module tb_top;

   import ifs_fern_pkg::*;

   typedef struct {
      logic [FRAC_W-1:0] frac;
      logic              frame;
   } fern_req_t;

   typedef struct {
      point_type          point_x;
      point_type          point_y;
      map_type            map;
      logic [SHADE_W-1:0] shade;
   } fern_pt_t;

   localparam int TOTAL_BEATS = 1350;
   localparam int CALM_TAIL   = 150;
   localparam int HOLD_CYCLES = 100;
   localparam int CLIMB_STEPS = MAX_SHADE + 5;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [FRAC_W-1:0]         req_random_fraction = '0;
   logic                      req_frame_start = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [POINT_W-1:0] rsp_point_x;
   logic signed [POINT_W-1:0] rsp_point_y;
   logic [1:0]                rsp_map_chosen;
   logic [SHADE_W-1:0]        rsp_shade_index;

   fern_req_t         pending_reqs[$];
   fern_pt_t          point_expect[$];
   fern_req_t         next_req;
   fern_pt_t          want_pt;
   fern_pt_t          got_pt;

   logic              beat_taken = 1'b0;
   logic [FRAC_W-1:0] taken_frac = '0;
   logic              taken_frame = 1'b0;
   logic              tail_calm = 1'b0;

   int                req_gap = 0;
   int                req_quiet = 0;
   int                rsp_stall = 0;
   int                rsp_quiet = 0;
   int                mismatches = 0;

   int                hold_left = 0;
   int                req_beats = 0;
   int                next_hold_at = 350;

   // kept point and shade state
   point_type          pos_x = '0;
   point_type          pos_y = '0;
   logic [SHADE_W-1:0] shade_st = '0;
   logic [STEP_W-1:0]  steps_st = '0;

   // ax, bx, cx, ay, by, cy in Q.16
   longint fern_coef [4][6] = '{
      '{ 56361,   1966, 0, -1966, 56361, 98304},
      '{  1311, -16384, 0, 13763, 15073, 98304},
      '{ -9830,  17695, 0, 16384, 17039, 29491},
      '{     0,      0, 0,     0, 11141,     0}
   };

   ifs_fern_point_generator_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_random_fraction (req_random_fraction),
      .req_frame_start     (req_frame_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_point_x         (rsp_point_x),
      .rsp_point_y         (rsp_point_y),
      .rsp_map_chosen      (rsp_map_chosen),
      .rsp_shade_index     (rsp_shade_index)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(5_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic point_type fern_affine(input longint a, input longint b,
                                             input longint c);
      longint s;
      longint v;
      point_type res;
      s = a * longint'(pos_x) + b * longint'(pos_y);
      v = ((s + 32768) >>> 16) + c;
      if (v > 64'sd8388607) begin
         res = Q_MAX;
      end else if (v < -64'sd8388608) begin
         res = Q_MIN;
      end else begin
         res = v[POINT_W-1:0];
      end
      return res;
   endfunction

   function automatic fern_pt_t next_fern_point(input logic [FRAC_W-1:0] frac,
                                                input logic frame);
      fern_pt_t p;
      map_type  m;
      int       k;
      if (frame) begin
         shade_st = '0;
         steps_st = '0;
      end
      if (frac < THR_0) begin
         m = MAP_STEM;
      end else if (frac < THR_1) begin
         m = MAP_RIGHT;
      end else if (frac < THR_2) begin
         m = MAP_LEFT;
      end else begin
         m = MAP_RETURN;
      end
      if (steps_st != STEP_MAX) begin
         steps_st = steps_st + 1'b1;
      end
      k = int'(m);
      p.point_x = fern_affine(fern_coef[k][0], fern_coef[k][1], fern_coef[k][2]);
      p.point_y = fern_affine(fern_coef[k][3], fern_coef[k][4], fern_coef[k][5]);
      if (m == MAP_RETURN) begin
         shade_st = '0;
         steps_st = '0;
      end
      p.map   = m;
      p.shade = shade_st;
      if (shade_st < MAX_SHADE && (int'(steps_st) / CLIMB_STEPS) > int'(shade_st)) begin
         shade_st = shade_st + 1'b1;
      end
      pos_x = p.point_x;
      pos_y = p.point_y;
      return p;
   endfunction

   task automatic queue_req(input int frac, input bit frame);
      fern_req_t it;
      it.frac  = frac[FRAC_W-1:0];
      it.frame = frame;
      pending_reqs.push_back(it);
   endtask

   // sender: one beat per handshake, random gaps until the calm tail
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         beat_taken <= 1'b0;
      end else begin
         tail_calm <= (pending_reqs.size() < CALM_TAIL);
         if (req_valid && req_ready) begin
            beat_taken  <= 1'b1;
            taken_frac  <= req_random_fraction;
            taken_frame <= req_frame_start;
         end else begin
            beat_taken <= 1'b0;
         end
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!tail_calm && req_quiet == 0 && $urandom_range(0, 9) == 0) begin
               req_gap   = $urandom_range(0, 14);
               req_quiet = $urandom_range(0, 40);
               req_valid <= 1'b0;
            end else begin
               next_req = pending_reqs.pop_front();
               req_random_fraction <= next_req.frac;
               req_frame_start     <= next_req.frame;
               req_valid           <= 1'b1;
               if (req_quiet != 0) begin
                  req_quiet = req_quiet - 1;
               end
            end
         end
      end
   end

   // long receiver hold-off, counted in cycles
   always @(posedge clock) begin
      if (reset) begin
         hold_left    <= 0;
         req_beats    <= 0;
         next_hold_at <= 350;
      end else begin
         if (req_valid && req_ready) begin
            req_beats <= req_beats + 1;
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (req_beats >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 550;
         end
      end
   end

   // receiver: predict each taken beat, then check the result beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (beat_taken) begin
            point_expect.push_back(next_fern_point(taken_frac, taken_frame));
         end
         if (rsp_valid && rsp_ready) begin
            got_pt.point_x = rsp_point_x;
            got_pt.point_y = rsp_point_y;
            got_pt.map     = map_type'(rsp_map_chosen);
            got_pt.shade   = rsp_shade_index;
            if (point_expect.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected point x=%0d y=%0d map=%0d shade=%0d", $time,
                           got_pt.point_x, got_pt.point_y, rsp_map_chosen, got_pt.shade);
               end
            end else begin
               want_pt = point_expect.pop_front();
               if (got_pt.point_x !== want_pt.point_x || got_pt.point_y !== want_pt.point_y ||
                   rsp_map_chosen !== want_pt.map || got_pt.shade !== want_pt.shade) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10) begin
                     $display("%0t: point mismatch x %0d/%0d y %0d/%0d map %0d/%0d shade %0d/%0d",
                              $time, want_pt.point_x, got_pt.point_x, want_pt.point_y,
                              got_pt.point_y, want_pt.map, rsp_map_chosen, want_pt.shade,
                              got_pt.shade);
                  end
               end
            end
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
         end else if (rsp_stall != 0) begin
            rsp_stall = rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else if (!tail_calm && rsp_quiet == 0 && $urandom_range(0, 9) == 0) begin
            rsp_stall = $urandom_range(0, 14);
            rsp_quiet = $urandom_range(0, 40);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_quiet != 0) begin
               rsp_quiet = rsp_quiet - 1;
            end
         end
      end
   end

   initial begin : stimulus
      int seg_len;
      int grow_runs;
      int thr;
      int n;
      // thresholds, field extremes and frame starts
      queue_req(0, 1'b1);
      queue_req(65535, 1'b0);
      queue_req(int'(THR_0) - 1, 1'b0);
      queue_req(int'(THR_0), 1'b0);
      queue_req(int'(THR_1) - 1, 1'b0);
      queue_req(int'(THR_1), 1'b0);
      queue_req(int'(THR_2) - 1, 1'b0);
      queue_req(int'(THR_2), 1'b0);
      queue_req(16'h5555, 1'b0);
      queue_req(16'hAAAA, 1'b0);
      queue_req(1, 1'b0);
      queue_req(32768, 1'b1);
      queue_req(int'(THR_1), 1'b1);
      queue_req(0, 1'b0);
      queue_req(int'(THR_2) - 1, 1'b0);
      queue_req(65535, 1'b1);
      queue_req(int'(THR_0) - 1, 1'b0);
      queue_req(0, 1'b0);
      grow_runs = 0;
      while (pending_reqs.size() < TOTAL_BEATS) begin
         if (grow_runs < 3 && pending_reqs.size() >= 120 + grow_runs * 400) begin
            // no return map: shade climbs to the top, step count saturates
            grow_runs = grow_runs + 1;
            seg_len = $urandom_range(260, 300);
            for (n = 0; n < seg_len; n++) begin
               queue_req($urandom_range(0, int'(THR_2) - 1),
                         n == 0 || $urandom_range(0, 199) == 0);
            end
         end else begin
            seg_len = $urandom_range(10, 60);
            for (n = 0; n < seg_len; n++) begin
               if ($urandom_range(0, 7) == 0) begin
                  case ($urandom_range(0, 2))
                     0: thr = int'(THR_0);
                     1: thr = int'(THR_1);
                     default: thr = int'(THR_2);
                  endcase
                  queue_req(thr - 2 + $urandom_range(0, 3), $urandom_range(0, 24) == 0);
               end else begin
                  queue_req($urandom_range(0, 65535), $urandom_range(0, 24) == 0);
               end
            end
         end
      end
      while (reset || pending_reqs.size() != 0 || req_valid || beat_taken ||
             point_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (mismatches == 0 && point_expect.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
src/ifs_fern_pkg.sv
src/ifs_fern_point_generator_top.sv
tb/sv/tb_top.sv
